// ----- sv/gsf_pkg.sv -----
package gsf_pkg;

    // Field widths
    localparam int IN_W       = 16;
    localparam int OUT_W      = 24;
    localparam int FAC_W      = 8;
    localparam int CFG_DATA_W = 8;
    localparam int REG_IDX_W  = 2;

    // Yaw boxcar length and fixed-point fraction (boxcar length must be a power of two)
    localparam int AVG_DEPTH = 4;
    localparam int FRAC_BITS = 8;
    localparam int POS_W     = $clog2(AVG_DEPTH);
    localparam int SUM_W     = IN_W + $clog2(AVG_DEPTH);

    // Axes
    localparam int NUM_AXES = 3;
    localparam int AXIS_W   = 2;
    localparam logic [AXIS_W-1:0] AX_ROLL  = 2'd0;
    localparam logic [AXIS_W-1:0] AX_PITCH = 2'd1;
    localparam logic [AXIS_W-1:0] AX_YAW   = 2'd2;

    // Datapath widths
    localparam int X_W    = IN_W + FRAC_BITS;
    localparam int PROD_W = OUT_W + FAC_W + 1;
    localparam int NUM_W  = ((PROD_W > X_W) ? PROD_W : X_W) + 1;
    localparam int AVGN_W = SUM_W + FRAC_BITS;
    localparam int DIV_W  = (NUM_W > AVGN_W) ? NUM_W : AVGN_W;

    // Serial divider: DIV_BPS quotient bits per cycle
    localparam int DIV_BPS    = 4;
    localparam int DIV_STEPS  = (DIV_W + DIV_BPS - 1) / DIV_BPS;
    localparam int DIV_MW     = DIV_STEPS * DIV_BPS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Configuration register map
    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROLL_FACTOR  = 2'd0,
        REG_PITCH_FACTOR = 2'd1,
        REG_YAW_FACTOR   = 2'd2,
        REG_TRI_MODE     = 2'd3
    } t_reg_idx;

    // Controller to datapath commands
    typedef struct packed {
        logic              load_in;
        logic              ring_upd;
        logic              div_start;
        logic              mul;
        logic              pass;
        logic              res_store;
        logic              out_load;
        logic [AXIS_W-1:0] axis;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic                pre_avg_en;
        logic [NUM_AXES-1:0] fac_active;
        logic                div_done;
        logic                out_free;
    } t_dp_stat;

endpackage

// ----- sv/gsf_in_if.sv -----
interface gsf_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [gsf_pkg::IN_W-1:0]   rate_roll;
    logic signed [gsf_pkg::IN_W-1:0]   rate_pitch;
    logic signed [gsf_pkg::IN_W-1:0]   rate_yaw;

    modport source (output valid, output rate_roll, output rate_pitch, output rate_yaw,
                    input ready);
    modport sink (input valid, input rate_roll, input rate_pitch, input rate_yaw,
                  output ready);
endinterface

// ----- sv/gsf_out_if.sv -----
interface gsf_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [gsf_pkg::OUT_W-1:0]  smooth_roll;
    logic signed [gsf_pkg::OUT_W-1:0]  smooth_pitch;
    logic signed [gsf_pkg::OUT_W-1:0]  smooth_yaw;

    modport source (output valid, output smooth_roll, output smooth_pitch, output smooth_yaw,
                    input ready);
    modport sink (input valid, input smooth_roll, input smooth_pitch, input smooth_yaw,
                  output ready);
endinterface

// ----- sv/gsf_cfg_if.sv -----
interface gsf_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [gsf_pkg::REG_IDX_W-1:0]        index;
    logic [gsf_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/gsf_div.sv -----
module gsf_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [gsf_pkg::DIV_W-1:0]   i_dividend,
    input  logic [gsf_pkg::FAC_W-1:0]          i_divisor,
    output logic                               o_done,
    output logic signed [gsf_pkg::DIV_W-1:0]   o_quot
);

    logic                               r_busy;
    logic                               r_done;
    logic [gsf_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [gsf_pkg::FAC_W-1:0]          r_rem;
    logic [gsf_pkg::DIV_MW-1:0]         r_quo;
    logic [gsf_pkg::FAC_W-1:0]          r_den;
    logic                               r_neg;

    logic [gsf_pkg::DIV_W-1:0]          mag;
    logic [gsf_pkg::FAC_W-1:0]          step_rem;
    logic [gsf_pkg::DIV_MW-1:0]         step_quo;
    logic [gsf_pkg::FAC_W:0]            rem_ext;

    // Magnitude of the dividend; quotient sign is applied at the end
    assign mag = i_dividend[gsf_pkg::DIV_W-1] ? gsf_pkg::DIV_W'(-i_dividend)
                                              : gsf_pkg::DIV_W'(i_dividend);

    // Restoring division, DIV_BPS bits per cycle
    always_comb begin
        step_rem = r_rem;
        step_quo = r_quo;
        rem_ext  = '0;
        for (int k = 0; k < gsf_pkg::DIV_BPS; k++) begin
            rem_ext  = {step_rem, step_quo[gsf_pkg::DIV_MW-1]};
            step_quo = {step_quo[gsf_pkg::DIV_MW-2:0], 1'b0};
            if (rem_ext >= {1'b0, r_den}) begin
                rem_ext     = rem_ext - {1'b0, r_den};
                step_quo[0] = 1'b1;
            end
            step_rem = rem_ext[gsf_pkg::FAC_W-1:0];
        end
    end

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + gsf_pkg::DIV_CNT_W'(1);
                if (r_cnt == gsf_pkg::DIV_CNT_W'(gsf_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= gsf_pkg::DIV_MW'(mag);
            r_den <= i_divisor;
            r_neg <= i_dividend[gsf_pkg::DIV_W-1];
        end else if (r_busy) begin
            r_rem <= step_rem;
            r_quo <= step_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -signed'(r_quo[gsf_pkg::DIV_W-1:0])
                          : signed'(r_quo[gsf_pkg::DIV_W-1:0]);

endmodule

// ----- sv/gsf_datapath.sv -----
module gsf_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gsf_pkg::t_dp_cmd                   i_cmd,
    output gsf_pkg::t_dp_stat                  o_stat,
    input  logic signed [gsf_pkg::IN_W-1:0]    i_rate_roll,
    input  logic signed [gsf_pkg::IN_W-1:0]    i_rate_pitch,
    input  logic signed [gsf_pkg::IN_W-1:0]    i_rate_yaw,
    input  logic                               i_cfg_valid,
    input  logic [gsf_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [gsf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [gsf_pkg::OUT_W-1:0]   o_smooth_roll,
    output logic signed [gsf_pkg::OUT_W-1:0]   o_smooth_pitch,
    output logic signed [gsf_pkg::OUT_W-1:0]   o_smooth_yaw
);

    localparam logic signed [gsf_pkg::DIV_W-1:0] SAT_HI =
        {{(gsf_pkg::DIV_W - gsf_pkg::OUT_W + 1){1'b0}}, {(gsf_pkg::OUT_W - 1){1'b1}}};
    localparam logic signed [gsf_pkg::DIV_W-1:0] SAT_LO =
        {{(gsf_pkg::DIV_W - gsf_pkg::OUT_W + 1){1'b1}}, {(gsf_pkg::OUT_W - 1){1'b0}}};

    // Configuration
    logic [gsf_pkg::FAC_W-1:0]          r_fac [gsf_pkg::NUM_AXES];
    logic                               r_tri;

    // Working sample and yaw boxcar
    logic signed [gsf_pkg::X_W-1:0]     r_x [gsf_pkg::NUM_AXES];
    logic signed [gsf_pkg::IN_W-1:0]    r_raw_yaw;
    logic signed [gsf_pkg::IN_W-1:0]    r_ring [gsf_pkg::AVG_DEPTH];
    logic [gsf_pkg::POS_W-1:0]          r_pos;
    logic signed [gsf_pkg::SUM_W-1:0]   r_sum;
    logic signed [gsf_pkg::SUM_W-1:0]   n_sum;

    // Smoothing
    logic signed [gsf_pkg::PROD_W-1:0]  r_prod;
    logic signed [gsf_pkg::OUT_W-1:0]   r_prev [gsf_pkg::NUM_AXES];
    logic signed [gsf_pkg::OUT_W-1:0]   r_res [gsf_pkg::NUM_AXES];
    logic signed [gsf_pkg::OUT_W-1:0]   r_out [gsf_pkg::NUM_AXES];
    logic                               r_out_valid;

    logic signed [gsf_pkg::AVGN_W-1:0]  avg_num;
    logic signed [gsf_pkg::AVGN_W-1:0]  avg_mean;
    logic signed [gsf_pkg::DIV_W-1:0]   axis_num;
    logic signed [gsf_pkg::DIV_W-1:0]   div_dividend;
    logic [gsf_pkg::FAC_W-1:0]          div_divisor;
    logic                               div_done;
    logic signed [gsf_pkg::DIV_W-1:0]   div_q;

    function automatic logic signed [gsf_pkg::OUT_W-1:0] sat_out(
        input logic signed [gsf_pkg::DIV_W-1:0] v
    );
        logic signed [gsf_pkg::DIV_W-1:0] c;
        c = v;
        if (v > SAT_HI) c = SAT_HI;
        if (v < SAT_LO) c = SAT_LO;
        return c[gsf_pkg::OUT_W-1:0];
    endfunction

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < gsf_pkg::NUM_AXES; a++) r_fac[a] <= '0;
            r_tri <= 1'b0;
        end else if (i_cfg_valid) begin
            case (gsf_pkg::t_reg_idx'(i_cfg_index))
                gsf_pkg::REG_ROLL_FACTOR:  r_fac[gsf_pkg::AX_ROLL]  <= i_cfg_data;
                gsf_pkg::REG_PITCH_FACTOR: r_fac[gsf_pkg::AX_PITCH] <= i_cfg_data;
                gsf_pkg::REG_YAW_FACTOR:   r_fac[gsf_pkg::AX_YAW]   <= i_cfg_data;
                gsf_pkg::REG_TRI_MODE:     r_tri <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Running boxcar sum: drop the oldest entry, add the new one
    assign n_sum = r_sum - gsf_pkg::SUM_W'(r_ring[r_pos]) + gsf_pkg::SUM_W'(r_raw_yaw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < gsf_pkg::AVG_DEPTH; i++) r_ring[i] <= '0;
            r_pos <= '0;
            r_sum <= '0;
        end else if (i_cmd.ring_upd) begin
            r_ring[r_pos] <= r_raw_yaw;
            r_sum         <= n_sum;
            if (r_pos == gsf_pkg::POS_W'(gsf_pkg::AVG_DEPTH - 1)) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + gsf_pkg::POS_W'(1);
            end
        end
    end

    // Boxcar mean of the updated ring, truncated toward zero
    assign avg_num  = gsf_pkg::AVGN_W'(n_sum) <<< gsf_pkg::FRAC_BITS;
    assign avg_mean = avg_num / gsf_pkg::AVGN_W'(gsf_pkg::AVG_DEPTH);

    // Divider operand select
    assign axis_num     = gsf_pkg::DIV_W'(r_prod) + gsf_pkg::DIV_W'(r_x[i_cmd.axis]);
    assign div_dividend = axis_num;
    assign div_divisor  = r_fac[i_cmd.axis];

    gsf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // Sample capture, product and per-axis results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x[gsf_pkg::AX_ROLL]  <= {i_rate_roll, gsf_pkg::FRAC_BITS'(0)};
            r_x[gsf_pkg::AX_PITCH] <= {i_rate_pitch, gsf_pkg::FRAC_BITS'(0)};
            r_x[gsf_pkg::AX_YAW]   <= {i_rate_yaw, gsf_pkg::FRAC_BITS'(0)};
            r_raw_yaw              <= i_rate_yaw;
        end else if (i_cmd.ring_upd) begin
            r_x[gsf_pkg::AX_YAW] <= avg_mean[gsf_pkg::X_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= r_prev[i_cmd.axis]
                    * signed'({1'b0, r_fac[i_cmd.axis] - gsf_pkg::FAC_W'(1)});
        end
        if (i_cmd.pass) begin
            r_res[i_cmd.axis] <= sat_out(gsf_pkg::DIV_W'(r_x[i_cmd.axis]));
        end else if (i_cmd.res_store) begin
            r_res[i_cmd.axis] <= sat_out(div_q);
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    // Last smoothed value per axis
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < gsf_pkg::NUM_AXES; a++) r_prev[a] <= '0;
        end else if (i_cmd.res_store) begin
            r_prev[i_cmd.axis] <= sat_out(div_q);
        end
    end

    // Output register: hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Status
    always_comb begin
        o_stat.pre_avg_en = r_tri && (r_fac[gsf_pkg::AX_YAW] != '0);
        for (int a = 0; a < gsf_pkg::NUM_AXES; a++) begin
            o_stat.fac_active[a] = r_fac[a] > gsf_pkg::FAC_W'(1);
        end
        o_stat.div_done = div_done;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_smooth_roll  = r_out[gsf_pkg::AX_ROLL];
    assign o_smooth_pitch = r_out[gsf_pkg::AX_PITCH];
    assign o_smooth_yaw   = r_out[gsf_pkg::AX_YAW];

endmodule

// ----- sv/gsf_ctrl.sv -----
module gsf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gsf_pkg::t_dp_stat   i_stat,
    output gsf_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RING,
        ST_AXIS,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    logic [gsf_pkg::AXIS_W-1:0]     r_axis;
    logic [gsf_pkg::AXIS_W-1:0]     n_axis;
    logic                           last_axis;

    assign last_axis = (r_axis == gsf_pkg::AXIS_W'(gsf_pkg::NUM_AXES - 1));

    // Sequence: optional yaw boxcar, then each axis in turn, then hand off
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_axis        = gsf_pkg::AX_ROLL;
                    n_state       = i_stat.pre_avg_en ? ST_RING : ST_AXIS;
                end
            end
            ST_RING: begin
                o_cmd.ring_upd = 1'b1;
                n_state        = ST_AXIS;
            end
            ST_AXIS: begin
                if (i_stat.fac_active[r_axis]) begin
                    o_cmd.mul = 1'b1;
                    n_state   = ST_DIV_START;
                end else begin
                    o_cmd.pass = 1'b1;
                    if (last_axis) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_axis = r_axis + gsf_pkg::AXIS_W'(1);
                    end
                end
            end
            ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.res_store = 1'b1;
                    if (last_axis) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_axis  = r_axis + gsf_pkg::AXIS_W'(1);
                        n_state = ST_AXIS;
                    end
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and axis index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// ----- sv/gyro_smoothing_filter_top.sv -----
// Three-axis gyro smoother. Each input beat (roll, pitch, yaw integer rates) gives one output
// beat of rates in signed fixed point with FRAC_BITS fractional bits. With tri_mode set and a
// nonzero yaw_factor, yaw first goes through an AVG_DEPTH-entry boxcar average; then every axis
// whose factor N is above 1 gives y = (last*(N-1)+x)/N, truncated toward zero and saturated to
// 24 bits, and keeps y as its new last value. Items are handled one at a time: each item goes
// through the yaw boxcar step when it runs, then through every axis in turn, either passed
// through or, for a smoothed axis, multiplied and then divided on the single shared serial
// divider, and is handed off before the next item can be taken. The result sits in an output
// register, so the next item is accepted while it waits; the last hand-off waits only if that
// register is still full. Configuration writes are always taken and belong in idle periods.
module gyro_smoothing_filter_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gsf_in_if.sink       i_in,
    gsf_out_if.source    o_out,
    gsf_cfg_if.sink      i_cfg
);

    gsf_pkg::t_dp_cmd    dp_cmd;
    gsf_pkg::t_dp_stat   dp_stat;
    logic                in_ready;

    gsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    gsf_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_rate_roll    (i_in.rate_roll),
        .i_rate_pitch   (i_in.rate_pitch),
        .i_rate_yaw     (i_in.rate_yaw),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_smooth_roll  (o_out.smooth_roll),
        .o_smooth_pitch (o_out.smooth_pitch),
        .o_smooth_yaw   (o_out.smooth_yaw)
    );

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

`ifndef SYNTHESIS
    // One item at a time: after an accepted beat the input stays closed
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while an item is in flight");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("output register overwritten");

    // Boxcar advances only when the yaw pre-average is enabled
    a_ring_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.ring_upd |-> dp_stat.pre_avg_en)
        else $error("yaw ring updated with pre-average off");

    // The divider does not report done right after a start
    a_div_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.div_start |=> !dp_stat.div_done)
        else $error("divider done right after start");
`endif

endmodule
